/* hw/rtl/letter_deque_with_delete_by_value_assert.svh */
// Assertion macros shared by the letter deque RTL.
// No dependencies; included by the modules that carry checks.
`ifndef LETTER_DEQUE_WITH_DELETE_BY_VALUE_ASSERT_SVH
`define LETTER_DEQUE_WITH_DELETE_BY_VALUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LDQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LDQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ldq_pkg.sv */
// Shared types and codes for the letter deque.
// No dependencies; used by every module of the block but ldq_ram.
`timescale 1ns / 1ps

package ldq_pkg;

	localparam int CAPACITY_DEF = 64;

	// Operation codes.
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_DELETE     = 3'd4;
	localparam logic [2:0] OP_SEARCH     = 3'd5;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// Read address select.
	localparam logic [1:0] RD_PTR   = 2'd0;
	localparam logic [1:0] RD_FRONT = 2'd1;
	localparam logic [1:0] RD_BACK  = 2'd2;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] letter;
	} ldq_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] position;
		logic [6:0] count;
		logic [7:0] front_letter;
		logic [7:0] back_letter;
	} ldq_out_t;

	typedef struct packed {
		logic       load;
		logic       set_status;
		logic [1:0] status;
		logic       push_front;
		logic       push_back;
		logic       pop_front;
		logic       pop_back;
		logic       scan_start;
		logic       scan_step;
		logic       found;
		logic       shift_write;
		logic       shift_done;
		logic [1:0] rd_sel;
		logic       cap_front;
		logic       cap_back;
		logic       clear_ends;
		logic       publish;
	} ldq_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       empty;
		logic       full;
		logic       match;
		logic       read_done;
		logic       out_busy;
	} ldq_sts_t;

endpackage

/* hw/rtl/ldq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ldq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/ldq_dpath.sv */
// Datapath of the letter deque: circular letter store, pointers, result register.
// Depends on ldq_pkg, ldq_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "letter_deque_with_delete_by_value_assert.svh"

module ldq_dpath #(
	parameter int CAPACITY = ldq_pkg::CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ldq_pkg::ldq_in_t  in_data,
	input  ldq_pkg::ldq_cmd_t cmd,
	output ldq_pkg::ldq_sts_t sts,
	output logic             out_valid,
	input  logic             out_ready,
	output ldq_pkg::ldq_out_t out_data
);

	import ldq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [AW:0] CAP_W = (AW + 1)'(CAPACITY);
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

	logic [2:0]    op_q;
	logic [7:0]    letter_q;
	logic [1:0]    status_q;
	logic [CW-1:0] pos_q;
	logic [7:0]    front_q;
	logic [7:0]    back_q;
	ldq_out_t      out_q;
	logic          out_valid_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] cmp_q;
	logic          rvalid_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cmp_m1;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] tail_addr;
	logic [AW-1:0] ptr_addr;
	logic [AW-1:0] back_addr;
	logic [AW-1:0] shift_addr;
	logic          ptr_live;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// Physical slot of a logical position, counted from the front.
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= CAP_W) begin
			s = s - CAP_W;
		end
		return s[AW-1:0];
	endfunction

	always_comb begin
		cnt_m1     = cnt_q - CW'(1);
		cmp_m1     = cmp_q - CW'(1);
		head_dec   = (head_q == '0) ? LAST_SLOT : head_q - AW'(1);
		head_inc   = wrap_add(head_q, AW'(1));
		tail_addr  = wrap_add(head_q, cnt_q[AW-1:0]);
		ptr_addr   = wrap_add(head_q, ptr_q[AW-1:0]);
		back_addr  = wrap_add(head_q, cnt_m1[AW-1:0]);
		shift_addr = wrap_add(head_q, cmp_m1[AW-1:0]);
		ptr_live   = ptr_q < cnt_q;
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_FRONT: ram_raddr = head_q;
			RD_BACK:  ram_raddr = back_addr;
			default:  ram_raddr = ptr_addr;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = shift_addr;
		ram_wdata = ram_rdata;
		if (cmd.push_front) begin
			ram_we    = 1'b1;
			ram_waddr = head_dec;
			ram_wdata = letter_q;
		end else if (cmd.push_back) begin
			ram_we    = 1'b1;
			ram_waddr = tail_addr;
			ram_wdata = letter_q;
		end else if (cmd.shift_write && rvalid_q) begin
			// Each letter behind the deleted one moves one place toward the front.
			ram_we    = 1'b1;
		end
	end

	ldq_ram #(
		.WIDTH(8),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts.op        = op_q;
		sts.empty     = (cnt_q == '0);
		sts.full      = (cnt_q == CAP_C);
		sts.match     = rvalid_q && (ram_rdata == letter_q);
		sts.read_done = !rvalid_q && !ptr_live;
		sts.out_busy  = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			cmp_q       <= '0;
			rvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push_front) begin
				head_q <= head_dec;
				cnt_q  <= cnt_q + CW'(1);
			end else if (cmd.push_back) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.pop_front) begin
				head_q <= head_inc;
				cnt_q  <= cnt_m1;
			end else if (cmd.pop_back || cmd.shift_done) begin
				cnt_q <= cnt_m1;
			end

			if (cmd.scan_start) begin
				ptr_q    <= '0;
				rvalid_q <= 1'b0;
			end else if (cmd.found) begin
				ptr_q    <= cmp_q + CW'(1);
				rvalid_q <= 1'b0;
			end else if (cmd.scan_step) begin
				rvalid_q <= ptr_live;
				cmp_q    <= ptr_q;
				if (ptr_live) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end

			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_data.operation;
			letter_q <= in_data.letter;
			status_q <= ST_OK;
			pos_q    <= '0;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.found) begin
			pos_q <= cmp_q;
		end
		if (cmd.clear_ends) begin
			front_q <= '0;
			back_q  <= '0;
		end
		if (cmd.cap_front) begin
			front_q <= ram_rdata;
		end
		if (cmd.cap_back) begin
			back_q <= ram_rdata;
		end
		if (cmd.publish) begin
			out_q.status       <= status_q;
			out_q.position     <= 6'(pos_q);
			out_q.count        <= 7'(cnt_q);
			out_q.front_letter <= front_q;
			out_q.back_letter  <= back_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LDQ_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CAP_C,
		"letter count above capacity")
	`LDQ_ASSERT_IMP(a_push_room, clk, arst_n, cmd.push_front || cmd.push_back,
		cnt_q != CAP_C, "push commanded into a full store")
	`LDQ_ASSERT_IMP(a_pop_live, clk, arst_n, cmd.pop_front || cmd.pop_back || cmd.shift_done,
		cnt_q != '0, "removal commanded on an empty store")
	`LDQ_ASSERT_IMP(a_shift_slot, clk, arst_n, cmd.shift_write && rvalid_q, cmp_q != '0,
		"shift write aimed in front of the first slot")
	`LDQ_ASSERT_NXT(a_publish, clk, arst_n, cmd.publish, out_valid_q,
		"result not presented after publish")

endmodule

/* hw/rtl/ldq_ctrl.sv */
// Controller state machine of the letter deque.
// Depends on ldq_pkg; drives the datapath through ldq_cmd_t.
`timescale 1ns / 1ps

module ldq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output ldq_pkg::ldq_cmd_t cmd,
	input  ldq_pkg::ldq_sts_t sts
);

	import ldq_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_FRONT = 3'd4;
	localparam logic [2:0] S_BACK  = 3'd5;
	localparam logic [2:0] S_BACKW = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		cmd.rd_sel = RD_PTR;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FRONT;
				unique case (sts.op) inside
					OP_PUSH_FRONT: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.push_front = 1'b1;
						end
					end
					OP_PUSH_BACK: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.push_back = 1'b1;
						end
					end
					OP_POP_FRONT: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.pop_front = 1'b1;
						end
					end
					OP_POP_BACK: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.pop_back = 1'b1;
						end
					end
					OP_DELETE, OP_SEARCH: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				// Reads are issued one per cycle; each compare happens in the cycle after its read.
				if (sts.match) begin
					cmd.found = 1'b1;
					state_d   = (sts.op == OP_DELETE) ? S_SHIFT : S_FRONT;
				end else if (sts.read_done) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_MISSING;
					state_d        = S_FRONT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_SHIFT: begin
				if (sts.read_done) begin
					cmd.shift_done = 1'b1;
					state_d        = S_FRONT;
				end else begin
					cmd.scan_step   = 1'b1;
					cmd.shift_write = 1'b1;
				end
			end
			S_FRONT: begin
				if (sts.empty) begin
					cmd.clear_ends = 1'b1;
					state_d        = S_DONE;
				end else begin
					cmd.rd_sel = RD_FRONT;
					state_d    = S_BACK;
				end
			end
			S_BACK: begin
				cmd.rd_sel    = RD_BACK;
				cmd.cap_front = 1'b1;
				state_d       = S_BACKW;
			end
			S_BACKW: begin
				cmd.cap_back = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

/* hw/rtl/letter_deque_with_delete_by_value.sv */
// Letter deque with delete and search by value: one operation per transfer in, one
// result per transfer out, one operation in flight at a time. Letters sit in a single
// circular RAM with one read and one write port, so a search or delete runs as a
// scan over the stored letters, one read a cycle (a delete's compaction continues on
// the same port). A finished result waits in an output register, so the next
// transfer in is taken while the previous result is still pending. No clearing pass
// follows reset. Depends on ldq_pkg, ldq_ctrl and ldq_dpath.
`timescale 1ns / 1ps

module letter_deque_with_delete_by_value #(
	parameter int CAPACITY = ldq_pkg::CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ldq_pkg::ldq_in_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ldq_pkg::ldq_out_t out_data
);

	import ldq_pkg::*;

	ldq_cmd_t cmd;
	ldq_sts_t sts;

	ldq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ldq_dpath #(
		.CAPACITY(CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the letter deque with delete and search by value.
// Drives operations over valid/ready, predicts every result from its own deque model
// and compares each result transfer field by field. Depends on ldq_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
	import ldq_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = CAPACITY + 16;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MAX_PRINTED = 50;

	// Codes the block must treat as no operation.
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ldq_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ldq_out_t out_data;

	logic [7:0] model_letters[$];
	ldq_out_t pending_results[$];

	bit idle_on = 1'b1;
	int hold_cycles = 0;
	int mismatch_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int status_tally[4] = '{0, 0, 0, 0};
	int peak_count = 0;
	int stall_count = 0;

	letter_deque_with_delete_by_value #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one operation to the deque model and returns the result it should produce.
	function automatic ldq_out_t apply_operation(logic [2:0] op, logic [7:0] ltr);
		ldq_out_t r;
		int idx;
		r = '0;
		r.status = ST_OK;
		idx = -1;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (model_letters.size() >= CAPACITY)
					r.status = ST_FULL;
				else if (op == OP_PUSH_FRONT)
					model_letters.push_front(ltr);
				else
					model_letters.push_back(ltr);
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (model_letters.size() == 0)
					r.status = ST_EMPTY;
				else if (op == OP_POP_FRONT)
					void'(model_letters.pop_front());
				else
					void'(model_letters.pop_back());
			end
			OP_DELETE, OP_SEARCH: begin
				if (model_letters.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int i = 0; i < model_letters.size() && idx < 0; i++)
						if (model_letters[i] == ltr)
							idx = i;
					if (idx < 0) begin
						r.status = ST_MISSING;
					end else begin
						r.position = idx[5:0];
						if (op == OP_DELETE)
							model_letters.delete(idx);
					end
				end
			end
			default: ;
		endcase
		r.count = 7'(model_letters.size());
		if (model_letters.size() != 0) begin
			r.front_letter = model_letters[0];
			r.back_letter = model_letters[model_letters.size() - 1];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string field, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
	endtask

	// Offers one operation and waits for its transfer; valid stays high from one item
	// to the next unless the sender takes a gap.
	task automatic send_item(input logic [2:0] op, input logic [7:0] ltr);
		ldq_out_t want;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{operation: op, letter: ltr};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		want = apply_operation(op, ltr);
		pending_results.push_back(want);
		status_tally[want.status]++;
		if (int'(want.count) > peak_count)
			peak_count = int'(want.count);
		items_sent++;
	endtask

	// Weighted random operation. Letters come from a small alphabet, from the letters
	// already stored, or from the full byte range, so that searches both hit and miss.
	task automatic random_item(input int push_w, input int pop_w, input int find_w);
		int pick;
		int sel;
		logic [2:0] op;
		logic [7:0] ltr;
		pick = $urandom_range(0, push_w + pop_w + find_w);
		if (pick < push_w)
			op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		else if (pick < push_w + pop_w)
			op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
		else if (pick < push_w + pop_w + find_w)
			op = $urandom_range(0, 1) ? OP_DELETE : OP_SEARCH;
		else
			op = $urandom_range(0, 1) ? OP_SPARE_B : OP_SPARE_A;
		sel = $urandom_range(0, 3);
		if (sel == 0 || model_letters.size() == 0)
			ltr = 8'($urandom_range(0, 255));
		else if (sel == 1)
			ltr = 8'(8'h41 + $urandom_range(0, 7));
		else
			ltr = model_letters[$urandom_range(0, model_letters.size() - 1)];
		send_item(op, ltr);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_empty_store();
		send_item(OP_POP_FRONT, 8'h00);
		send_item(OP_POP_BACK, 8'hFF);
		send_item(OP_DELETE, 8'h41);
		send_item(OP_SEARCH, 8'h41);
		send_item(OP_SPARE_A, 8'h00);
		send_item(OP_SPARE_B, 8'hFF);
	endtask

	task automatic test_directed_ops();
		send_item(OP_PUSH_BACK, 8'h00);
		send_item(OP_PUSH_FRONT, 8'hFF);
		send_item(OP_PUSH_BACK, 8'hA5);
		send_item(OP_PUSH_FRONT, 8'h5A);
		send_item(OP_SEARCH, 8'hA5);
		send_item(OP_SEARCH, 8'h00);
		send_item(OP_SEARCH, 8'h33);
		// A duplicate at the back: the delete must take the one nearer the front.
		send_item(OP_PUSH_BACK, 8'hFF);
		send_item(OP_DELETE, 8'hFF);
		send_item(OP_SEARCH, 8'hFF);
		send_item(OP_SPARE_A, 8'h12);
		send_item(OP_SPARE_B, 8'hED);
		send_item(OP_POP_FRONT, 8'h00);
		send_item(OP_POP_BACK, 8'h00);
		send_item(OP_DELETE, 8'h00);
		send_item(OP_DELETE, 8'h77);
		send_item(OP_DELETE, 8'hA5);
		send_item(OP_SEARCH, 8'hA5);
	endtask

	task automatic test_fill_to_overflow();
		repeat (300) random_item(8, 1, 2);
	endtask

	task automatic test_drain_to_empty();
		repeat (300) random_item(1, 5, 5);
	endtask

	task automatic test_random_mix();
		repeat (700) random_item(3, 3, 4);
	endtask

	// The receiver holds off while the sender keeps offering, so the block backs up.
	task automatic test_receiver_hold();
		idle_on = 1'b0;
		hold_cycles = HOLD_OFF_CYCLES;
		repeat (30) random_item(3, 2, 2);
		idle_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		repeat (8) begin
			repeat ($urandom_range(1, 20)) random_item(3, 2, 3);
			wait_drained();
		end
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		repeat (500) random_item(4, 3, 4);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_directed_ops();
		test_fill_to_overflow();
		test_drain_to_empty();
		test_random_mix();
		wait_drained();
		test_receiver_hold();
		test_sender_pause();
		test_no_idle();
		wait_drained();
		$display("Run covered %0d operations and %0d result transfers, peak fill %0d of %0d.",
			items_sent, results_checked, peak_count, CAPACITY);
		$display("Status seen: ok %0d, full %0d, empty %0d, not found %0d; mismatches %0d.",
			status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
			status_tally[ST_MISSING], mismatch_count);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Receiver: random stall bursts while idling is on, one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		ldq_out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with no operation outstanding");
			end else begin
				want = pending_results.pop_front();
				check_field("status", int'(out_data.status), int'(want.status));
				check_field("position", int'(out_data.position), int'(want.position));
				check_field("count", int'(out_data.count), int'(want.count));
				check_field("front_letter", int'(out_data.front_letter),
					int'(want.front_letter));
				check_field("back_letter", int'(out_data.back_letter),
					int'(want.back_letter));
			end
		end
	end

	// Ends the run if neither side completes a transfer for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
				STALL_LIMIT, pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule

/* letter_deque_with_delete_by_value.f */
+incdir+hw/rtl
hw/rtl/ldq_pkg.sv
hw/rtl/ldq_ram.sv
hw/rtl/ldq_dpath.sv
hw/rtl/ldq_ctrl.sv
hw/rtl/letter_deque_with_delete_by_value.sv
tb/testbench.sv
